### hdl/rdmf_pkg.sv
// Shared types and constants for the table-driven Mealy/Moore control automaton.
// No dependencies; every other file in hdl/ imports this package.
package rdmf_pkg;

    // Sizing of the automaton
    localparam int STATE_BITS  = 4;
    localparam int GROUP_BITS  = 2;
    localparam int INPUT_BITS  = 8;
    localparam int OUTPUT_BITS = 8;

    // Fixed widths of the channel fields
    localparam int OP_W        = 2;
    localparam int CI_W        = 8;
    localparam int ROW_FIELD_W = 4;
    localparam int COL_FIELD_W = 4;
    localparam int VAL_W       = 8;
    localparam int ST_FIELD_W  = 4;
    localparam int CW_W        = 8;

    // Table geometry
    localparam int CELL_W     = 8;
    localparam int NUM_ROWS   = 1 << STATE_BITS;
    localparam int NUM_COLS   = 1 + (2 << GROUP_BITS);
    localparam int COL_W      = $clog2(NUM_COLS);
    localparam int NUM_GROUPS = (INPUT_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W      = NUM_GROUPS * GROUP_BITS;

    localparam logic [COL_W-1:0] GROUP_COL = '0;
    localparam logic [COL_W-1:0] MOORE_COL = COL_W'(1 + (1 << GROUP_BITS));

    localparam logic [CI_W-1:0] IN_MASK  = CI_W'((64'd1 << INPUT_BITS) - 64'd1);
    localparam logic [CW_W-1:0] OUT_MASK = CW_W'((64'd1 << OUTPUT_BITS) - 64'd1);

    typedef logic [NUM_COLS-1:0][CELL_W-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_STEP  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FORCE = 2'd2
    } op_t;

    typedef enum logic {
        MODE_MEALY = 1'b0,
        MODE_MOORE = 1'b1
    } mode_t;

endpackage

### hdl/rdmf_if.sv
// Valid/ready channel interfaces for the automaton's item and result streams.
// Depends on rdmf_pkg for field widths.
interface rdmf_in_if import rdmf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [CI_W-1:0]        control_inputs;
    logic [ROW_FIELD_W-1:0] table_row;
    logic [COL_FIELD_W-1:0] table_column;
    logic [VAL_W-1:0]       table_value;
    logic [ST_FIELD_W-1:0]  forced_state;

    modport source (
        output valid, operation, control_inputs, table_row, table_column,
               table_value, forced_state,
        input  ready
    );
    modport sink (
        input  valid, operation, control_inputs, table_row, table_column,
               table_value, forced_state,
        output ready
    );
endinterface

interface rdmf_out_if import rdmf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CW_W-1:0]       control_word;
    logic [ST_FIELD_W-1:0] current_state;
    logic                  group_error;

    modport source (
        output valid, control_word, current_state, group_error,
        input  ready
    );
    modport sink (
        input  valid, control_word, current_state, group_error,
        output ready
    );
endinterface

### hdl/rom_driven_mealy_moore_fsm.sv
// Top level of the table-driven Mealy/Moore control automaton.
// Depends on rdmf_pkg, the channel interfaces in rdmf_if and rdmf_table.
//
//  channel   kind        direction  transfer when
//  in_item   valid/ready in         in_item.valid && in_item.ready
//  out_item  valid/ready out        out_item.valid && out_item.ready
//  cfg       write only  in         cfg_we high (automaton_mode)
//
// Each item is decoded and applied as it transfers: one per cycle unless stalled.
// The state register and table are updated at that edge; the result lands in a
// one-deep output register, so the next item reads the updated state and table.
// in_item.ready drops only while a result waits and out_item.ready is low.
// Reset clears the state register, the mode and the result valid; the table is
// not cleared.
module rom_driven_mealy_moore_fsm import rdmf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    rdmf_in_if.sink    in_item,
    rdmf_out_if.source out_item,
    input  logic  cfg_we,
    input  logic  cfg_wdata
);

    logic [STATE_BITS-1:0] state_reg;
    logic [STATE_BITS-1:0] state_next;
    mode_t                 mode_reg;
    logic                  out_valid_reg;
    logic [CW_W-1:0]       word_reg;
    logic [CW_W-1:0]       word_next;
    logic                  err_reg;
    logic                  err_next;

    logic                  accept;
    logic                  tbl_we;
    logic                  cell_in_range;
    row_t                  row_cells;
    logic [CELL_W-1:0]     grp_cell;
    logic                  grp_err;
    logic [GRP_W-1:0]      grp_sel;
    logic [CI_W-1:0]       ctrl_in;
    logic [PAD_W-1:0]      padded;
    logic [GROUP_BITS-1:0] grp_val;
    logic [COL_W-1:0]      next_col;
    logic [COL_W-1:0]      word_col;

    assign in_item.ready = !out_valid_reg || out_item.ready;
    assign accept        = in_item.valid && in_item.ready;

    rdmf_table u_table (
        .clk      (clk),
        .wr_en    (tbl_we),
        .wr_row   (STATE_BITS'(in_item.table_row)),
        .wr_col   (COL_W'(in_item.table_column)),
        .wr_data  (in_item.table_value),
        .rd_row   (state_reg),
        .rd_cells (row_cells)
    );

    // Group selection: clamp an out-of-range index to the last group
    assign grp_cell = row_cells[GROUP_COL];
    assign grp_err  = (32'(grp_cell) >= NUM_GROUPS);
    assign grp_sel  = grp_err ? GRP_W'(NUM_GROUPS - 1) : GRP_W'(grp_cell);
    assign ctrl_in  = in_item.control_inputs & IN_MASK;

    // Pad the inputs with zeros up to a whole number of groups
    always_comb
    begin
        padded = '0;
        for (int b = 0; b < PAD_W; b++)
        begin
            if (b < CI_W)
            begin
                padded[b] = ctrl_in[b];
            end
        end
    end

    assign grp_val = padded[grp_sel * GROUP_BITS +: GROUP_BITS];

    always_comb
    begin
        if (mode_reg == MODE_MOORE)
        begin
            next_col = COL_W'(grp_val) + COL_W'(1);
            word_col = MOORE_COL;
        end
        else
        begin
            next_col = COL_W'({grp_val, 1'b0}) + COL_W'(1);
            word_col = COL_W'({grp_val, 1'b0}) + COL_W'(2);
        end
    end

    assign cell_in_range = (32'(in_item.table_row) < NUM_ROWS)
                        && (32'(in_item.table_column) < NUM_COLS);

    always_comb
    begin
        state_next = state_reg;
        word_next  = '0;
        err_next   = 1'b0;
        tbl_we     = 1'b0;
        case (op_t'(in_item.operation))
            OP_STEP:
            begin
                state_next = row_cells[next_col][STATE_BITS-1:0];
                word_next  = CW_W'(row_cells[word_col]) & OUT_MASK;
                err_next   = grp_err;
            end
            OP_WRITE:
            begin
                tbl_we = accept && cell_in_range;
            end
            OP_FORCE:
            begin
                state_next = STATE_BITS'(in_item.forced_state);
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            mode_reg      <= MODE_MEALY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= mode_t'(cfg_wdata);
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next transfer in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
            err_reg  <= err_next;
        end
    end

    assign out_item.valid         = out_valid_reg;
    assign out_item.control_word  = word_reg;
    assign out_item.current_state = ST_FIELD_W'(state_reg);
    assign out_item.group_error   = err_reg;

endmodule

### hdl/rdmf_table.sv
// Program table: one row per state, one cell written per cycle, whole row read.
// Depends on rdmf_pkg for the table geometry and row type.
module rdmf_table import rdmf_pkg::*; (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [STATE_BITS-1:0] wr_row,
    input  logic [COL_W-1:0]      wr_col,
    input  logic [CELL_W-1:0]     wr_data,
    input  logic [STATE_BITS-1:0] rd_row,
    output row_t                  rd_cells
);

    row_t table_reg [NUM_ROWS];

    // Contents are undefined until written, so no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[wr_row][wr_col] <= wr_data;
        end
    end

    assign rd_cells = table_reg[rd_row];

endmodule
